// ===== rtl/buart_pkg.sv =====
// Shared types and constants for the buffered 8N1 UART.
package buart_pkg;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_PUSH = 2'd1,
    KIND_POP  = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam logic CFG_TICKS_PER_BIT  = 1'b0;
  localparam logic CFG_HALF_BIT_TICKS = 1'b1;

  localparam logic [15:0] TICKS_PER_BIT_RESET  = 16'd52;
  localparam logic [14:0] HALF_BIT_TICKS_RESET = 15'd26;

  // Frame geometry: start + 8 data + stop
  localparam logic [3:0] TX_FRAME_BITS = 4'd10;
  localparam logic [3:0] RX_DATA_BITS  = 4'd8;

  // Receiver to FIFO: a byte finished on this tick
  typedef struct packed {
    logic       done;
    logic [7:0] data;
  } buart_rx_evt_t;

endpackage

// ===== rtl/buffered_uart_8n1.sv =====
// Buffered full-duplex 8N1 UART top level: FIFOs, transmitter, handshakes.
// A beat accepted into the input register moves on to the result register and leaves as a result beat.
// Throughput: one beat per cycle while out_stall is low; the input register doubles as the skid stage.
// Reset (synchronous, rst_n low): pointers, serializer and receiver state,
// handshake valids and config registers (52 / 26) clear; the FIFO stores are
// left as they are and only ever read after being written.
module buffered_uart_8n1 #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic        in_rx_line,
  input  logic [7:0]  in_tx_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_line,
  output logic        out_push_refused,
  output logic [7:0]  out_rx_data,
  output logic        out_rx_valid,
  output logic [3:0]  out_rx_level,
  output logic [3:0]  out_tx_level,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import buart_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  // A FIFO holds at most depth-1 bytes
  localparam logic [PW-1:0] FULL_LVL = PW'(FIFO_DEPTH - 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);

  function automatic logic [PW-1:0] lvl(input logic [PW-1:0] w, input logic [PW-1:0] r);
    logic [PW:0] d;
    d = {1'b0, w} - {1'b0, r};
    if (d[PW]) begin
      d = d + (PW + 1)'(FIFO_DEPTH);
    end
    return d[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [15:0] tpb_r;
  logic [14:0] half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpb_r  <= TICKS_PER_BIT_RESET;
      half_r <= HALF_BIT_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TICKS_PER_BIT:  tpb_r  <= cfg_wdata;
        CFG_HALF_BIT_TICKS: half_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Input register / skid stage
  // ---------------------------------------------------------------
  logic       s1_valid_r;
  logic [1:0] s1_kind_r;
  logic       s1_rx_line_r;
  logic [7:0] s1_tx_data_r;
  logic       adv;
  logic       in_take;

  // The held beat moves on whenever the result register is free or draining.
  assign adv      = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r    <= in_kind;
      s1_rx_line_r <= in_rx_line;
      s1_tx_data_r <= in_tx_data;
    end
  end

  logic do_tick, do_push, do_pop;

  always_comb begin
    do_tick = 1'b0;
    do_push = 1'b0;
    do_pop  = 1'b0;
    case (kind_t'(s1_kind_r))
      KIND_TICK: do_tick = adv;
      KIND_PUSH: do_push = adv;
      KIND_POP:  do_pop  = adv;
      default: ;  // unused kind: no action; report line and levels only
    endcase
  end

  // ---------------------------------------------------------------
  // FIFO pointers and stores
  // ---------------------------------------------------------------
  logic [PW-1:0] tx_wp_r, tx_rp_r, rx_wp_r, rx_rp_r;
  logic [PW-1:0] tx_wp_nxt, tx_rp_nxt, rx_wp_nxt, rx_rp_nxt;
  logic [PW-1:0] tx_lvl, rx_lvl;
  logic [7:0]    tx_mem [FIFO_DEPTH];
  logic [7:0]    rx_mem [FIFO_DEPTH];
  logic [7:0]    tx_byte_r;   // byte now on the wire, read from tx_mem
  logic [7:0]    rx_rd_r;     // last popped byte, read from rx_mem

  assign tx_lvl = lvl(tx_wp_r, tx_rp_r);
  assign rx_lvl = lvl(rx_wp_r, rx_rp_r);

  logic push_ok, push_refused, pop_ok, tx_load;
  buart_rx_evt_t rx_evt;
  logic rx_wr;

  assign push_ok      = do_push && (tx_lvl != FULL_LVL);
  assign push_refused = do_push && (tx_lvl == FULL_LVL);
  assign pop_ok       = do_pop && (rx_lvl != '0);
  // Drop a received byte when the receive FIFO is full
  assign rx_wr        = rx_evt.done && (rx_lvl != FULL_LVL);

  // ---------------------------------------------------------------
  // Transmit serializer
  // ---------------------------------------------------------------
  logic [3:0]  tx_bits_left_r, tx_bits_left_nxt;
  logic [15:0] tx_cnt_r, tx_cnt_nxt;
  logic        tx_line_r, tx_line_nxt;
  logic [3:0]  bl;
  logic [15:0] cnt;
  logic [16:0] cnt_inc;

  assign tx_load = do_tick && (tx_bits_left_r == 4'd0) && (tx_lvl != '0);

  always_comb begin
    tx_bits_left_nxt = tx_bits_left_r;
    tx_cnt_nxt       = tx_cnt_r;
    tx_line_nxt      = tx_line_r;
    bl               = tx_load ? TX_FRAME_BITS : tx_bits_left_r;
    cnt              = tx_load ? 16'd0 : tx_cnt_r;
    cnt_inc          = 17'(cnt) + 17'd1;
    if (do_tick && bl != 4'd0) begin
      // Bit position in the frame is TX_FRAME_BITS - bits_left:
      // start bit first, data LSB first, stop bit last.
      if (bl == TX_FRAME_BITS) begin
        tx_line_nxt = 1'b0;
      end else if (bl == 4'd1) begin
        tx_line_nxt = 1'b1;
      end else begin
        tx_line_nxt = tx_byte_r[3'(4'd9 - bl)];
      end
      // A zero bit time behaves as one tick per bit.
      if (cnt_inc >= 17'(tpb_r)) begin
        tx_cnt_nxt       = 16'd0;
        tx_bits_left_nxt = bl - 4'd1;
      end else begin
        tx_cnt_nxt       = cnt_inc[15:0];
        tx_bits_left_nxt = bl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_bits_left_r <= 4'd0;
      tx_cnt_r       <= 16'd0;
      tx_line_r      <= 1'b1;
    end else begin
      tx_bits_left_r <= tx_bits_left_nxt;
      tx_cnt_r       <= tx_cnt_nxt;
      tx_line_r      <= tx_line_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Receiver
  // ---------------------------------------------------------------
  buart_rx u_rx (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick_en        (do_tick),
    .line           (s1_rx_line_r),
    .ticks_per_bit  (tpb_r),
    .half_bit_ticks (half_r),
    .evt            (rx_evt)
  );

  // ---------------------------------------------------------------
  // Pointer update and store access
  // ---------------------------------------------------------------
  assign tx_wp_nxt = push_ok ? bump(tx_wp_r) : tx_wp_r;
  assign tx_rp_nxt = tx_load ? bump(tx_rp_r) : tx_rp_r;
  assign rx_wp_nxt = rx_wr   ? bump(rx_wp_r) : rx_wp_r;
  assign rx_rp_nxt = pop_ok  ? bump(rx_rp_r) : rx_rp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wp_r <= '0;
      tx_rp_r <= '0;
      rx_wp_r <= '0;
      rx_rp_r <= '0;
    end else begin
      tx_wp_r <= tx_wp_nxt;
      tx_rp_r <= tx_rp_nxt;
      rx_wp_r <= rx_wp_nxt;
      rx_rp_r <= rx_rp_nxt;
    end
  end

  // Reads only target entries written on an earlier edge, since a load or pop
  // needs a nonzero level before the beat.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      tx_mem[tx_wp_r] <= s1_tx_data_r;
    end
    if (tx_load) begin
      tx_byte_r <= tx_mem[tx_rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_wr) begin
      rx_mem[rx_wp_r] <= rx_evt.data;
    end
    if (pop_ok) begin
      rx_rd_r <= rx_mem[rx_rp_r];
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  logic       out_valid_r;
  logic       out_tx_line_r;
  logic       out_push_refused_r;
  logic       out_rx_valid_r;
  logic [3:0] out_rx_level_r;
  logic [3:0] out_tx_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Levels past 15 wrap, as the result field is four bits.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_tx_line_r      <= tx_line_nxt;
      out_push_refused_r <= push_refused;
      out_rx_valid_r     <= pop_ok;
      out_rx_level_r     <= 4'(lvl(rx_wp_nxt, rx_rp_nxt));
      out_tx_level_r     <= 4'(lvl(tx_wp_nxt, tx_rp_nxt));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_line      = out_tx_line_r;
  assign out_push_refused = out_push_refused_r;
  // rx_rd_r only moves on a successful pop, so it holds while stalled
  assign out_rx_data      = out_rx_valid_r ? rx_rd_r : 8'd0;
  assign out_rx_valid     = out_rx_valid_r;
  assign out_rx_level     = out_rx_level_r;
  assign out_tx_level     = out_tx_level_r;

endmodule

// ===== rtl/buart_rx.sv =====
// Receive deserializer: start-edge detect, mid-bit sampling, byte assembly.
module buart_rx (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    tick_en,
  input  logic                    line,
  input  logic [15:0]             ticks_per_bit,
  input  logic [14:0]             half_bit_ticks,
  output buart_pkg::buart_rx_evt_t evt
);
  import buart_pkg::*;

  logic        busy_r, busy_nxt;
  logic [3:0]  bits_left_r, bits_left_nxt;
  logic [16:0] cnt_r, cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        prev_r, prev_nxt;
  logic        done_c;

  always_comb begin
    busy_nxt      = busy_r;
    bits_left_nxt = bits_left_r;
    cnt_nxt       = cnt_r;
    shift_nxt     = shift_r;
    prev_nxt      = line;
    done_c        = 1'b0;
    if (!busy_r) begin
      // falling edge opens a frame; first sample lands mid data bit 0
      if (prev_r && !line) begin
        busy_nxt      = 1'b1;
        bits_left_nxt = RX_DATA_BITS;
        cnt_nxt       = 17'(ticks_per_bit) + 17'(half_bit_ticks);
      end
    end else if (cnt_r > 17'd1) begin
      cnt_nxt = cnt_r - 17'd1;
    end else begin
      shift_nxt = {line, shift_r[7:1]};
      if (bits_left_r != 4'd0) begin
        bits_left_nxt = bits_left_r - 4'd1;
      end
      if (bits_left_nxt == 4'd0) begin
        done_c   = 1'b1;
        busy_nxt = 1'b0;
        cnt_nxt  = 17'd0;
      end else begin
        cnt_nxt = 17'(ticks_per_bit);
      end
    end
  end

  assign evt.done = tick_en & done_c;
  assign evt.data = shift_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      bits_left_r <= 4'd0;
      cnt_r       <= 17'd0;
      shift_r     <= 8'd0;
      prev_r      <= 1'b1;
    end else if (tick_en) begin
      busy_r      <= busy_nxt;
      bits_left_r <= bits_left_nxt;
      cnt_r       <= cnt_nxt;
      shift_r     <= shift_nxt;
      prev_r      <= prev_nxt;
    end
  end

endmodule

// ===== tb/buffered_uart_8n1_tb.sv =====
// Self-checking testbench for the buffered 8N1 UART: tick, push and pop beats vs. a predictor.
`timescale 1ns / 100ps

module buffered_uart_8n1_tb;
  import buart_pkg::*;

  localparam int FIFO_DEPTH = 16;
  // Kind code that the block must treat as a no-op
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Cycles without any accepted beat before the run is declared hung
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic       tx_line;
    logic       push_refused;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic [3:0] rx_level;
    logic [3:0] tx_level;
  } uart_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_TICK;
  logic        in_rx_line = 1'b1;
  logic [7:0]  in_tx_data = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_tx_line;
  logic        out_push_refused;
  logic [7:0]  out_rx_data;
  logic        out_rx_valid;
  logic [3:0]  out_rx_level;
  logic [3:0]  out_tx_level;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = CFG_TICKS_PER_BIT;
  logic [15:0] cfg_wdata = 16'h0000;

  buffered_uart_8n1 #(.FIFO_DEPTH(FIFO_DEPTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_rx_line       (in_rx_line),
    .in_tx_data       (in_tx_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_line      (out_tx_line),
    .out_push_refused (out_push_refused),
    .out_rx_data      (out_rx_data),
    .out_rx_valid     (out_rx_valid),
    .out_rx_level     (out_rx_level),
    .out_tx_level     (out_tx_level),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of everything the UART remembers
  // ---------------------------------------------------------------------------
  logic [15:0] bit_ticks  = TICKS_PER_BIT_RESET;
  logic [14:0] half_ticks = HALF_BIT_TICKS_RESET;

  logic [7:0]  txq_mem [FIFO_DEPTH];
  logic [7:0]  rxq_mem [FIFO_DEPTH];
  logic [3:0]  txq_wr = '0, txq_rd = '0, rxq_wr = '0, rxq_rd = '0;

  // Serializer: frame shifts out LSB first, one bit per bit_ticks ticks
  logic [9:0]  ser_frame = '0;
  logic [3:0]  ser_bits  = '0;
  logic [15:0] ser_count = '0;
  logic        line_out  = 1'b1;

  // Deserializer: counts down to each sample point
  logic [7:0]  des_shift = '0;
  logic [3:0]  des_bits  = '0;
  logic [16:0] des_count = '0;
  logic        des_busy  = 1'b0;
  logic        des_prev  = 1'b1;

  uart_result_t expected_results [$];
  bit           rx_wave [$];       // rx line levels queued for upcoming ticks
  int           mismatch_count = 0;
  int           quiet_cycles   = 0;
  int           in_idle_pct    = 0;
  int           out_idle_pct   = 0;

  function automatic logic [3:0] fifo_fill(logic [3:0] wr, logic [3:0] rd);
    return wr - rd;
  endfunction

  // Advance the predicted UART by one accepted beat and return its result.
  function automatic uart_result_t predict_beat(logic [1:0] kind, logic line,
                                                logic [7:0] data);
    uart_result_t res;
    res = '0;
    case (kind)
      KIND_TICK: begin
        // Transmitter: load the next byte when the line is free
        if (ser_bits == 0 && fifo_fill(txq_wr, txq_rd) != 0) begin
          ser_frame = {1'b1, txq_mem[txq_rd], 1'b0};
          txq_rd    = txq_rd + 1'b1;
          ser_bits  = TX_FRAME_BITS;
          ser_count = '0;
        end
        if (ser_bits != 0) begin
          line_out  = ser_frame[0];
          ser_count = ser_count + 1'b1;
          // A bit time of 0 behaves as 1 since the count is already 1 here
          if (ser_count >= bit_ticks) begin
            ser_count = '0;
            ser_frame = ser_frame >> 1;
            ser_bits  = ser_bits - 1'b1;
          end
        end
        // Receiver: only a high-to-low transition opens a frame
        if (!des_busy) begin
          if (des_prev && !line) begin
            des_busy  = 1'b1;
            des_bits  = RX_DATA_BITS;
            des_count = {1'b0, bit_ticks} + {2'b00, half_ticks};
          end
        end else if (des_count > 1) begin
          des_count = des_count - 1'b1;
        end else begin
          des_shift = {line, des_shift[7:1]};
          if (des_bits > 0) des_bits = des_bits - 1'b1;
          if (des_bits == 0) begin
            // Drop the byte when the receive FIFO has no room
            if (fifo_fill(rxq_wr, rxq_rd) < FIFO_DEPTH - 1) begin
              rxq_mem[rxq_wr] = des_shift;
              rxq_wr = rxq_wr + 1'b1;
            end
            des_busy  = 1'b0;
            des_count = '0;
          end else begin
            des_count = {1'b0, bit_ticks};
          end
        end
        des_prev = line;
      end
      KIND_PUSH: begin
        if (fifo_fill(txq_wr, txq_rd) < FIFO_DEPTH - 1) begin
          txq_mem[txq_wr] = data;
          txq_wr = txq_wr + 1'b1;
        end else begin
          res.push_refused = 1'b1;
        end
      end
      KIND_POP: begin
        if (fifo_fill(rxq_wr, rxq_rd) != 0) begin
          res.rx_data  = rxq_mem[rxq_rd];
          res.rx_valid = 1'b1;
          rxq_rd = rxq_rd + 1'b1;
        end
      end
      default: ;
    endcase
    res.tx_line  = line_out;
    res.rx_level = fifo_fill(rxq_wr, rxq_rd);
    res.tx_level = fifo_fill(txq_wr, txq_rd);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, compare each result beat with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    uart_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat arrived with no prediction pending");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("tx_line",      want.tx_line,      out_tx_line);
        check_field("push_refused", want.push_refused, out_push_refused);
        check_field("rx_data",      want.rx_data,      out_rx_data);
        check_field("rx_valid",     want.rx_valid,     out_rx_valid);
        check_field("rx_level",     want.rx_level,     out_rx_level);
        check_field("tx_level",     want.tx_level,     out_tx_level);
      end
    end
  end

  // Watchdog: any beat on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one input beat, with a random gap first; returns at the accepting edge
  // with in_valid still high, so the caller either offers the next beat or drops it.
  task automatic send_beat(input logic [1:0] kind, input logic line, input logic [7:0] data);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_rx_line <= line;
    in_tx_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_beat(kind, line, data));
  endtask

  // Drop valid and hold until every predicted result has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_TICKS_PER_BIT) bit_ticks = value;
    else half_ticks = value[14:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_bit_timing(input logic [15:0] tpb, input logic [15:0] half);
    wait_drained();
    write_reg(CFG_TICKS_PER_BIT, tpb);
    write_reg(CFG_HALF_BIT_TICKS, half);
  endtask

  // Queue an 8N1 frame (or now and then a long break) on the rx line at the
  // current bit time, preceded by a short idle-high stretch.
  task automatic queue_rx_frame();
    int         span;
    logic [9:0] frame;
    span = (bit_ticks == 0) ? 1 : int'(bit_ticks);
    repeat ($urandom_range(3, 1)) rx_wave.push_back(1'b1);
    if ($urandom_range(9) == 0) begin
      repeat (12 * span) rx_wave.push_back(1'b0);
    end else begin
      frame = {1'b1, 8'($urandom_range(255)), 1'b0};
      for (int b = 0; b < 10; b++) begin
        repeat (span) rx_wave.push_back(frame[b]);
      end
    end
  endtask

  // Mixed traffic: ticks follow queued rx frames (with some line noise),
  // pushes and pops in the given proportions, a few unused-kind beats.
  task automatic run_traffic(input int beats, input int tick_pct, input int push_pct,
                             input int noise_pct);
    int   pick;
    logic line;
    for (int n = 0; n < beats; n++) begin
      // Now and then hold off the sender until the block has fully drained
      if ($urandom_range(199) == 0) wait_drained();
      pick = $urandom_range(99);
      if (pick < 2) begin
        send_beat(KIND_UNUSED, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end else if (pick < tick_pct) begin
        if (rx_wave.size() == 0) queue_rx_frame();
        line = rx_wave.pop_front();
        if ($urandom_range(99) < noise_pct) line = 1'($urandom_range(1));
        send_beat(KIND_TICK, line, 8'($urandom_range(255)));
      end else if (pick < tick_pct + push_pct) begin
        send_beat(KIND_PUSH, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end else begin
        send_beat(KIND_POP, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
  endtask

  // Bit time with a first-sample offset that lands inside each data bit.
  task automatic random_timing(input int lo, input int hi);
    int span;
    span = $urandom_range(hi, lo);
    set_bit_timing(16'(span), 16'($urandom_range(span <= 1 ? 0 : span - 1, span / 2)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values, empty pop, unused kind, byte extremes, TX FIFO full.
  task automatic test_reset_corners();
    send_beat(KIND_POP, 1'b1, 8'h00);
    send_beat(KIND_UNUSED, 1'b0, 8'hA5);
    send_beat(KIND_TICK, 1'b1, 8'h00);
    send_beat(KIND_TICK, 1'b1, 8'hFF);
    send_beat(KIND_PUSH, 1'b0, 8'h00);
    send_beat(KIND_PUSH, 1'b1, 8'hFF);
    repeat (FIFO_DEPTH - 3) send_beat(KIND_PUSH, 1'b0, 8'($urandom_range(255)));
    // FIFO now holds depth-1 bytes: this push must be refused
    send_beat(KIND_PUSH, 1'b1, 8'h5A);
    send_beat(KIND_POP, 1'b0, 8'h00);
    // First tick starts the start bit
    send_beat(KIND_TICK, 1'b1, 8'h00);
  endtask

  // Largest register values, with ticks while a TX bit is in progress.
  task automatic test_register_extremes();
    // All ones on the write data; the half-bit register keeps 15 bits
    set_bit_timing(16'hFFFF, 16'hFFFF);
    send_beat(KIND_PUSH, 1'b0, 8'($urandom_range(255)));
    // Keep rx high so no frame is opened with the huge first-sample delay
    repeat (20) send_beat(KIND_TICK, 1'b1, 8'($urandom_range(255)));
    send_beat(KIND_POP, 1'b1, 8'h00);
  endtask

  // Bit times of 0 and 1 with zero half-bit offset, then the smallest legal pair.
  task automatic test_short_bit_times();
    set_bit_timing(16'd0, 16'd0);
    run_traffic(70, 80, 12, 0);
    set_bit_timing(16'd1, 16'd0);
    run_traffic(60, 80, 10, 0);
    set_bit_timing(16'd2, 16'd1);
    run_traffic(60, 80, 10, 2);
  endtask

  // Three mixes: balanced, RX-heavy with rare pops (receive overflow), push-heavy.
  task automatic test_random_traffic();
    random_timing(2, 6);
    run_traffic(220, 70, 15, 5);
    random_timing(0, 2);
    run_traffic(220, 85, 12, 3);
    random_timing(8, 16);
    run_traffic(220, 45, 40, 10);
  endtask

  initial begin
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      txq_mem[i] = '0;
      rxq_mem[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender mostly busy, receiver mostly stalling
    in_idle_pct  = 22;
    out_idle_pct = 72;
    test_reset_corners();
    test_register_extremes();
    test_short_bit_times();
    test_random_traffic();

    // Sender sparse, receiver mostly ready
    in_idle_pct  = 72;
    out_idle_pct = 22;
    test_random_traffic();

    // Full rate both ways
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_traffic();

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
